[design/ctw_pkg.sv]
// Package for the text-mode console writer.
// Holds the transfer payload types, command and state codes and fixed constants.
// No dependencies.
`default_nettype none

package ctw_pkg;

  localparam int CURSOR_W = 11;
  localparam int ROW_MAX_W = 6;
  localparam int COL_MAX_W = 8;
  localparam int CELL_W = 14;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] ATTR_RESET = 8'h07;

  localparam logic [1:0] OP_PUT = 2'd0;
  localparam logic [1:0] OP_LOCATE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [4:0] row;
    logic [6:0] column;
  } cmd_item_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_cell;
    logic                scrolled;
    logic [7:0]          read_char;
    logic [7:0]          read_attr;
  } rsp_item_t;

  typedef enum logic [2:0] {
    CMD_PUT_CHAR,
    CMD_NEWLINE,
    CMD_LOCATE,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [7:0]           char_code;
    logic [ROW_MAX_W-1:0] row;
    logic [COL_MAX_W-1:0] col;
    logic [CELL_W-1:0]    cell_addr;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DONE,
    ST_CLEAR,
    ST_SCROLL,
    ST_ZERO
  } st_t;

endpackage

`default_nettype wire

[design/ctw_front.sv]
// Front end of the console writer: accepts command transfers and classifies them.
// Clamps row and column and forms the cell index. Depends on ctw_pkg.
`default_nettype none

module ctw_front import ctw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic      cmd_valid,
  output logic           cmd_ready,
  input  wire cmd_item_t cmd,
  input  wire logic      queue_full,
  input  wire logic      init_busy,
  output logic           push,
  output cmd_t           push_cmd
);

  logic [6:0] row_ext;
  logic [7:0] col_ext;
  logic [ROW_MAX_W-1:0] row_cl;
  logic [COL_MAX_W-1:0] col_cl;

  assign cmd_ready = !queue_full && !init_busy;
  assign push = cmd_valid && cmd_ready;

  assign row_ext = 7'(cmd.row);
  assign col_ext = 8'(cmd.column);

  always_comb begin
    if (row_ext > 7'(ROWS - 1)) begin
      row_cl = ROW_MAX_W'(ROWS - 1);
    end else begin
      row_cl = row_ext[ROW_MAX_W-1:0];
    end
    if (col_ext > 8'(COLS - 1)) begin
      col_cl = COL_MAX_W'(COLS - 1);
    end else begin
      col_cl = col_ext;
    end
  end

  always_comb begin
    push_cmd.char_code = cmd.char_code;
    push_cmd.row = row_cl;
    push_cmd.col = col_cl;
    push_cmd.cell_addr = CELL_W'(row_cl * COLS + col_cl);
    unique case (cmd.opcode)
      OP_PUT: begin
        push_cmd.kind = (cmd.char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT_CHAR;
      end
      OP_LOCATE: push_cmd.kind = CMD_LOCATE;
      OP_CLEAR:  push_cmd.kind = CMD_CLEAR;
      OP_READ:   push_cmd.kind = CMD_READ;
      default:   push_cmd.kind = CMD_READ;
    endcase
  end

endmodule

`default_nettype wire

[design/ctw_queue.sv]
// Two-entry command queue between the front and back ends of the console writer.
// Depends on ctw_pkg for the command type.
`default_nettype none

module ctw_queue import ctw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output cmd_t      head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[design/ctw_back.sv]
// Back end of the console writer: cell memory, cursor, scroll and clear sweeps.
// Drives the result register. Depends on ctw_pkg.
`default_nettype none

module ctw_back import ctw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] text_attribute,
  input  wire logic       q_valid,
  input  wire cmd_t       q_head,
  output logic            q_pop,
  output logic            init_busy,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output rsp_item_t       rsp
);

  localparam int CELLS = COLS * ROWS;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(COLS * (ROWS - 1));

  logic [15:0] mem [CELLS];
  logic [15:0] rd_data;

  st_t state;
  st_t state_next;
  logic [ADDR_W-1:0] sweep;
  logic cp_valid;
  logic [ADDR_W-1:0] cp_addr;
  logic clr_emit;
  logic pend_scrolled;
  logic pend_read;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [ADDR_W-1:0] cur_cell;

  logic we;
  logic [ADDR_W-1:0] wa;
  logic [15:0] wd;
  logic re;
  logic [ADDR_W-1:0] ra;
  logic load;
  logic last_row;
  logic last_col;
  logic put_wrap;
  logic [CELL_W-1:0] cell_ext;

  assign last_row = (cur_row == ROW_W'(ROWS - 1));
  assign last_col = (cur_col == COL_W'(COLS - 1));
  assign put_wrap = last_row && last_col;
  assign init_busy = (state == ST_CLEAR) && !clr_emit;
  assign cell_ext = CELL_W'(cur_cell);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_head.kind)
            CMD_PUT_CHAR: state_next = put_wrap ? ST_SCROLL : ST_DONE;
            CMD_NEWLINE:  state_next = last_row ? ST_SCROLL : ST_DONE;
            CMD_CLEAR:    state_next = ST_CLEAR;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (sweep == LAST_CELL) begin
          state_next = clr_emit ? ST_DONE : ST_IDLE;
        end
      end
      ST_SCROLL: begin
        if (sweep == LAST_CELL) begin
          state_next = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (!cp_valid && sweep == LAST_CELL) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    we = 1'b0;
    wa = cur_cell;
    wd = {text_attribute, q_head.char_code};
    re = 1'b0;
    ra = q_head.cell_addr[ADDR_W-1:0];
    load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_pop = q_valid;
        we = q_valid && (q_head.kind == CMD_PUT_CHAR);
        re = q_valid && (q_head.kind == CMD_READ);
      end
      ST_CLEAR: begin
        we = 1'b1;
        wa = sweep;
        wd = '0;
      end
      ST_SCROLL: begin
        re = 1'b1;
        ra = sweep;
        we = cp_valid;
        wa = cp_addr;
        wd = rd_data;
      end
      ST_ZERO: begin
        we = 1'b1;
        wa = cp_valid ? cp_addr : sweep;
        wd = cp_valid ? rd_data : '0;
      end
      ST_DONE: begin
        load = !rsp_valid || rsp_ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCROLL) begin
      cp_addr <= sweep - ADDR_W'(COLS);
    end
    if (load) begin
      rsp.cursor_cell <= cell_ext[CURSOR_W-1:0];
      rsp.scrolled <= pend_scrolled;
      rsp.read_char <= pend_read ? rd_data[7:0] : 8'd0;
      rsp.read_attr <= pend_read ? rd_data[15:8] : 8'd0;
    end
    if (q_pop) begin
      pend_scrolled <= ((q_head.kind == CMD_PUT_CHAR) && put_wrap) ||
                       ((q_head.kind == CMD_NEWLINE) && last_row);
      pend_read <= (q_head.kind == CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      sweep <= '0;
      clr_emit <= 1'b0;
      cp_valid <= 1'b0;
      cur_row <= '0;
      cur_col <= '0;
      cur_cell <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cp_valid <= (state == ST_SCROLL);
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            unique case (q_head.kind)
              CMD_PUT_CHAR: begin
                cur_cell <= cur_cell + 1'b1;
                if (last_col) begin
                  cur_col <= '0;
                  cur_row <= cur_row + 1'b1;
                end else begin
                  cur_col <= cur_col + 1'b1;
                end
              end
              CMD_NEWLINE: begin
                cur_col <= '0;
                cur_row <= cur_row + 1'b1;
                cur_cell <= ADDR_W'(cur_cell + COLS - cur_col);
              end
              CMD_LOCATE: begin
                cur_row <= q_head.row[ROW_W-1:0];
                cur_col <= q_head.col[COL_W-1:0];
                cur_cell <= q_head.cell_addr[ADDR_W-1:0];
              end
              CMD_CLEAR: begin
                cur_row <= '0;
                cur_col <= '0;
                cur_cell <= '0;
                sweep <= '0;
                clr_emit <= 1'b1;
              end
              default: begin
              end
            endcase
            if (state_next == ST_SCROLL) begin
              cur_row <= ROW_W'(ROWS - 1);
              cur_col <= '0;
              cur_cell <= LAST_ROW_BASE;
              sweep <= ADDR_W'(COLS);
            end
          end
        end
        ST_CLEAR: begin
          sweep <= sweep + 1'b1;
        end
        ST_SCROLL: begin
          sweep <= (sweep == LAST_CELL) ? LAST_ROW_BASE : sweep + 1'b1;
        end
        ST_ZERO: begin
          if (!cp_valid) begin
            sweep <= sweep + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/text_mode_console_writer.sv]
// Top level of the text-mode console writer: APB attribute register and the
// front end, command queue and back end. Depends on ctw_pkg and its submodules.
//
// Usage: commands arrive on the cmd channel (valid/ready); each one yields
// exactly one result transfer on the rsp channel (valid/ready), in order.
// The APB port holds one register, text_attribute, at byte address 0; pready
// is always high and a write lands in the access cycle.
// A command that does not scroll or clear passes through the queue, then the
// back end's issue and result states, before its result is registered; the
// back end issues the next command only once it leaves the result state.
// A scroll sweeps the cell memory through its single write port (copy rows
// up, then zero the last row) before the scrolling put or newline gets its
// result; a clear writes zero to every cell before its result.
// After reset a clearing pass writes zero to all COLS*ROWS cells, one a cycle;
// cmd_ready stays low during that pass, while APB writes are taken.
// When the receiver stalls, the result register holds its transfer and the
// two-entry queue keeps taking commands until it fills.
`default_nettype none

module text_mode_console_writer import ctw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire cmd_item_t   cmd,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output rsp_item_t        rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0] text_attribute;
  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic q_valid;
  cmd_t q_head;
  logic q_pop;
  logic init_busy;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_ATTRIBUTE) ? 32'(text_attribute) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_ATTRIBUTE) begin
      text_attribute <= pwdata[7:0];
    end
  end

  ctw_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .queue_full (queue_full),
    .init_busy  (init_busy),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  ctw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  ctw_back #(.COLS(COLS), .ROWS(ROWS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .text_attribute (text_attribute),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .init_busy      (init_busy),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp)
  );

endmodule

`default_nettype wire

[design/ctw_checker.sv]
// Port-level checker for the text-mode console writer, with its bind statement.
// Depends on ctw_pkg and the top level's ports.
`default_nettype none

module ctw_checker import ctw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      cmd_ready,
  input wire logic      rsp_valid,
  input wire logic      rsp_ready,
  input wire rsp_item_t rsp
);

  a_init_blocks_cmd: assert property (@(posedge clk) rst |=> !cmd_ready)
    else $error("Commands accepted during the clearing pass after reset.");

  a_reset_no_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("Result transfer offered right after reset.");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && rsp.scrolled |-> rsp.cursor_cell == CURSOR_W'(COLS * (ROWS - 1)))
    else $error("Scrolled result with cursor off the start of the last row.");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
      rsp_valid |-> (COLS * ROWS > 2048) || (32'(rsp.cursor_cell) < COLS * ROWS))
    else $error("Cursor cell beyond the screen.");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("Stalled result transfer dropped or changed.");

endmodule

bind text_mode_console_writer ctw_checker #(.COLS(COLS), .ROWS(ROWS)) u_ctw_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_ready (cmd_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
